[design/wsfe_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame encoder package
// Shared constants and types for the frame header builder and the encoder.
// ----------------------------------------------------------------------------
package wsfe_pkg;

  localparam int LenW        = 63;
  localparam int KeyW        = 32;
  localparam int HdrMax      = 14;
  localparam int HdrCntW     = $clog2(HdrMax + 1);

  localparam logic [6:0] LenShortMax = 7'd125;
  localparam logic [6:0] LenCode16   = 7'd126;
  localparam logic [6:0] LenCode64   = 7'd127;

  // request kinds carried in s_axis_tuser
  localparam logic ReqStart   = 1'b0;
  localparam logic ReqPayload = 1'b1;

  typedef logic [HdrMax-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    hdr_bytes_t         bytes;  // bytes[0] goes out first
    logic [HdrCntW-1:0] count;
  } hdr_t;

endpackage

[design/websocket_frame_encoder.sv]
// ----------------------------------------------------------------------------
// WebSocket frame encoder
// Turns frame-start and payload beats into an RFC 6455 framed byte stream.
// ----------------------------------------------------------------------------
// A taken beat is written into the byte buffer, and its bytes then pass through the output register.
// Unless m_axis_tready stalls the output, payload beats are taken at one per
// cycle; a frame-start beat holds the byte buffer until its header bytes
// (2 to 14) have left, one byte per cycle through the output register.
// Reset: asynchronous, clears masking state, length counter and both stages.
module websocket_frame_encoder import wsfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [0] fin, [4:1] opcode, [67:5] payload_length, [68] mask_present,
  // [100:69] mask_key, [101] premasked, [109:102] payload_byte, [111:110] zero
  input  logic [111:0] s_axis_tdata,
  // [0] req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]   m_axis_tdata,
  // end_of_run
  output logic         m_axis_tlast,
  // [0] is_header, [1] end_of_frame, [2] overrun_error
  output logic [2:0]   m_axis_tuser
);

  logic            fin;
  logic [3:0]      opcode;
  logic [LenW-1:0] payload_length;
  logic            mask_present;
  logic [KeyW-1:0] mask_key;
  logic            premasked;
  logic [7:0]      payload_byte;

  assign fin            = s_axis_tdata[0];
  assign opcode         = s_axis_tdata[4:1];
  assign payload_length = s_axis_tdata[67:5];
  assign mask_present   = s_axis_tdata[68];
  assign mask_key       = s_axis_tdata[100:69];
  assign premasked      = s_axis_tdata[101];
  assign payload_byte   = s_axis_tdata[109:102];

  hdr_t hdr;

  wsfe_hdr_build u_hdr_build (
    .fin_i            (fin),
    .opcode_i         (opcode),
    .payload_length_i (payload_length),
    .mask_present_i   (mask_present),
    .mask_key_i       (mask_key),
    .hdr_o            (hdr)
  );

  // frame state
  logic [KeyW-1:0] key_store_q, key_store_d;
  logic            xor_act_q, xor_act_d;
  logic [1:0]      key_idx_q, key_idx_d;
  logic [LenW-1:0] left_q, left_d;

  // byte buffer: results of the current beat, shifted out low byte first
  hdr_bytes_t         buf_q, buf_d;
  logic [HdrCntW-1:0] rem_q, rem_d;
  logic               hdr_q, hdr_d;
  logic               eof_q, eof_d;
  logic               err_q, err_d;

  // output register
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;
  logic [2:0] ouser_q, ouser_d;

  logic       out_free;
  logic       move;
  logic       s_fire;
  logic [7:0] key_byte;

  assign out_free      = !ovalid_q || m_axis_tready;
  assign move          = (rem_q != '0) && out_free;
  assign s_axis_tready = (rem_q == '0) || ((rem_q == HdrCntW'(1)) && move);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign key_byte      = key_store_q[{~key_idx_q, 3'b000} +: 8];

  always_comb begin
    key_store_d = key_store_q;
    xor_act_d   = xor_act_q;
    key_idx_d   = key_idx_q;
    left_d      = left_q;
    buf_d       = buf_q;
    rem_d       = rem_q;
    hdr_d       = hdr_q;
    eof_d       = eof_q;
    err_d       = err_q;
    if (s_fire) begin
      if (s_axis_tuser == ReqStart) begin
        buf_d       = hdr.bytes;
        rem_d       = hdr.count;
        hdr_d       = 1'b1;
        eof_d       = (payload_length == '0);
        err_d       = 1'b0;
        key_store_d = mask_key;
        xor_act_d   = mask_present && !premasked;
        key_idx_d   = 2'd0;
        left_d      = payload_length;
      end else if (left_q == '0) begin
        // overrun: byte dropped, frame state untouched
        buf_d    = '0;
        rem_d    = HdrCntW'(1);
        hdr_d    = 1'b0;
        eof_d    = 1'b0;
        err_d    = 1'b1;
      end else begin
        buf_d     = '0;
        buf_d[0]  = xor_act_q ? (payload_byte ^ key_byte) : payload_byte;
        rem_d     = HdrCntW'(1);
        hdr_d     = 1'b0;
        eof_d     = (left_q == LenW'(1));
        err_d     = 1'b0;
        key_idx_d = key_idx_q + 2'd1;
        left_d    = left_q - LenW'(1);
      end
    end else if (move) begin
      buf_d = {8'h00, buf_q[HdrMax-1:1]};
      rem_d = rem_q - HdrCntW'(1);
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    ouser_d  = ouser_q;
    if (move) begin
      ovalid_d = 1'b1;
      obyte_d  = buf_q[0];
      olast_d  = (rem_q == HdrCntW'(1));
      ouser_d  = {err_q, eof_q && (rem_q == HdrCntW'(1)), hdr_q};
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_store_q <= '0;
      xor_act_q   <= 1'b0;
      key_idx_q   <= 2'd0;
      left_q      <= '0;
      rem_q       <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      key_store_q <= key_store_d;
      xor_act_q   <= xor_act_d;
      key_idx_q   <= key_idx_d;
      left_q      <= left_d;
      rem_q       <= rem_d;
      ovalid_q    <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    hdr_q   <= hdr_d;
    eof_q   <= eof_d;
    err_q   <= err_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    ouser_q <= ouser_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = obyte_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = ouser_q;

endmodule

[design/wsfe_hdr_build.sv]
// ----------------------------------------------------------------------------
// WebSocket frame header builder
// Lays out the header run for one frame-start beat: opcode byte, length byte,
// extended length and masking key, with the number of bytes used.
// ----------------------------------------------------------------------------
module wsfe_hdr_build import wsfe_pkg::*; (
  input  logic            fin_i,
  input  logic [3:0]      opcode_i,
  input  logic [LenW-1:0] payload_length_i,
  input  logic            mask_present_i,
  input  logic [KeyW-1:0] mask_key_i,
  output hdr_t            hdr_o
);

  logic [63:0]        len64;
  logic               is_short;
  logic               is_mid;
  hdr_bytes_t         hb;
  logic [HdrCntW-1:0] cnt;

  assign len64    = {1'b0, payload_length_i};
  assign is_short = (payload_length_i <= LenW'(LenShortMax));
  assign is_mid   = (payload_length_i[LenW-1:16] == '0);

  always_comb begin
    hb    = '0;
    hb[0] = {fin_i, 3'b000, opcode_i};
    if (is_short) begin
      hb[1] = {mask_present_i, payload_length_i[6:0]};
      for (int k = 0; k < 4; k++) begin
        hb[2+k] = mask_present_i ? mask_key_i[8*(3-k) +: 8] : 8'h00;
      end
      cnt = HdrCntW'(2);
    end else if (is_mid) begin
      hb[1] = {mask_present_i, LenCode16};
      hb[2] = payload_length_i[15:8];
      hb[3] = payload_length_i[7:0];
      for (int k = 0; k < 4; k++) begin
        hb[4+k] = mask_present_i ? mask_key_i[8*(3-k) +: 8] : 8'h00;
      end
      cnt = HdrCntW'(4);
    end else begin
      hb[1] = {mask_present_i, LenCode64};
      for (int i = 0; i < 8; i++) begin
        hb[2+i] = len64[8*(7-i) +: 8];
      end
      for (int k = 0; k < 4; k++) begin
        hb[10+k] = mask_present_i ? mask_key_i[8*(3-k) +: 8] : 8'h00;
      end
      cnt = HdrCntW'(10);
    end
    if (mask_present_i) begin
      cnt = cnt + HdrCntW'(4);
    end
  end

  assign hdr_o.bytes = hb;
  assign hdr_o.count = cnt;

endmodule
